// File: hdl/imhq_pkg.sv
package imhq_pkg;

  localparam int KEY_W = 32;
  localparam int PAY_W = 32;
  localparam int ID_W  = 8;
  localparam int OP_W  = 2;
  localparam int ST_W  = 3;
  localparam int CAP_W = 9;
  localparam int SLOT_W = KEY_W + ID_W + PAY_W;
  localparam logic [CAP_W-1:0] CAP_RESET = 9'd256;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 2'd0,
    OP_REKEY  = 2'd1,
    OP_DELMIN = 2'd2,
    OP_REMOVE = 2'd3
  } op_t;

  localparam logic [ST_W-1:0] ST_OK        = 3'd0;
  localparam logic [ST_W-1:0] ST_FULL      = 3'd1;
  localparam logic [ST_W-1:0] ST_PRESENT   = 3'd2;
  localparam logic [ST_W-1:0] ST_NOT_FOUND = 3'd3;
  localparam logic [ST_W-1:0] ST_EMPTY     = 3'd4;

  typedef enum logic [3:0] {
    S_IDLE, S_LOOK, S_RDOLD, S_RDTOP, S_RDLAST,
    S_UP, S_UPC, S_DOWN, S_DNL, S_DNR, S_DNC, S_FIN
  } state_t;

  typedef struct packed {
    logic [PAY_W-1:0] pay;
    logic [ID_W-1:0]  id;
    logic [KEY_W-1:0] key;
  } slot_t;

endpackage

// File: hdl/imhq_ram.sv
module imhq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// File: hdl/imhq_cmp.sv
// shared signed key comparator
module imhq_cmp (
  input  logic [imhq_pkg::KEY_W-1:0] a,
  input  logic [imhq_pkg::KEY_W-1:0] b,
  output logic                       lt
);
  import imhq_pkg::*;
  assign lt = $signed(a) < $signed(b);
endmodule

// File: hdl/indexed_min_heap_queue_top.sv
// Indexed binary min-heap queue, one operation at a time.
// A refused item ends after its lookup; others sift up or down one heap level at a time.
// in_tready is high only while idle, and a stalled result holds the block.
// One slot read port and the shared comparator set the pace.
// Reset (rst_n low, synchronous): queue empty, all ids absent, capacity 256.
module indexed_min_heap_queue_top #(
  parameter int MAX_ENTRIES = 256,
  parameter int ID_COUNT    = 256
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  // item_id [7:0], new_key [39:8], payload_in [71:40]
  input  logic [71:0]                in_tdata,
  // operation [1:0]
  input  logic [imhq_pkg::OP_W-1:0]  in_tuser,
  output logic                       out_tvalid,
  input  logic                       out_tready,
  // out_id [7:0], out_key [39:8], out_payload [71:40]
  output logic [71:0]                out_tdata,
  // status [2:0]
  output logic [imhq_pkg::ST_W-1:0]  out_tuser,
  input  logic                       cfg_wr_en,
  input  logic [imhq_pkg::CAP_W-1:0] cfg_wr_data
);
  import imhq_pkg::*;

  localparam int PW   = $clog2(MAX_ENTRIES + 1);   // slot position, 1..MAX
  localparam int SAW  = $clog2(MAX_ENTRIES);       // slot memory address
  localparam int IDW  = (ID_COUNT > 1) ? $clog2(ID_COUNT) : 1;
  localparam int CW   = (PW > CAP_W) ? PW : CAP_W;

  state_t state_r, state_nxt;
  op_t op_r, op_nxt;
  logic [ID_W-1:0]  id_r, id_nxt;
  logic [KEY_W-1:0] nkey_r, nkey_nxt;
  logic [PAY_W-1:0] npay_r, npay_nxt;
  logic [CAP_W-1:0] cap_r;
  logic [PW-1:0]    cnt_r, cnt_nxt;
  logic [PW-1:0]    pos_r, pos_nxt;
  logic [PW-1:0]    c_r, c_nxt;
  slot_t            mv_r, mv_nxt;      // entry being sifted
  slot_t            ch_r, ch_nxt;      // left child / chosen child
  logic [KEY_W-1:0] old_r, old_nxt;
  logic [ID_COUNT-1:0] vld_r, vld_nxt;  // id present
  logic [ST_W-1:0]  res_st_r, res_st_nxt;
  slot_t            res_r, res_nxt;
  logic             out_valid_r;
  logic [ST_W-1:0]  out_st_r;
  slot_t            out_r;

  // slot memory
  logic             s_we;
  logic [SAW-1:0]   s_waddr, s_raddr;
  slot_t            s_wdata, s_rdata;
  // position memory
  logic             p_we;
  logic [IDW-1:0]   p_waddr, p_raddr;
  logic [PW-1:0]    p_wdata, p_rdata;

  logic [KEY_W-1:0] cmp_a, cmp_b;
  logic             cmp_lt;

  imhq_ram #(.WIDTH(SLOT_W), .DEPTH(MAX_ENTRIES)) u_slots (
    .clk(clk), .we(s_we), .waddr(s_waddr), .wdata(s_wdata),
    .raddr(s_raddr), .rdata(s_rdata)
  );

  imhq_ram #(.WIDTH(PW), .DEPTH(ID_COUNT)) u_pos (
    .clk(clk), .we(p_we), .waddr(p_waddr), .wdata(p_wdata),
    .raddr(p_raddr), .rdata(p_rdata)
  );

  imhq_cmp u_cmp (.a(cmp_a), .b(cmp_b), .lt(cmp_lt));

  function automatic logic [IDW-1:0] idx(input logic [ID_W-1:0] v);
    logic [16:0] e;
    e = 17'(v);
    return e[IDW-1:0];
  endfunction

  function automatic logic [SAW-1:0] saddr(input logic [PW-1:0] p);
    logic [PW-1:0] a;
    a = p - PW'(1);
    return a[SAW-1:0];
  endfunction

  logic [CW-1:0]   cap_eff;
  logic            full;
  logic            id_bad;
  logic [PW-1:0]   look_p;
  logic [PW:0]     c2;

  always_comb begin
    cap_eff = (CW'(cap_r) > CW'(MAX_ENTRIES)) ? CW'(MAX_ENTRIES) : CW'(cap_r);
    full    = CW'(cnt_r) >= cap_eff;
    id_bad  = 17'(id_r) >= 17'(ID_COUNT);
    look_p  = (!id_bad && vld_r[idx(id_r)]) ? p_rdata : '0;
    c2      = {pos_r, 1'b0};
  end

  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    state_nxt  = state_r;
    op_nxt     = op_r;
    id_nxt     = id_r;
    nkey_nxt   = nkey_r;
    npay_nxt   = npay_r;
    cnt_nxt    = cnt_r;
    pos_nxt    = pos_r;
    c_nxt      = c_r;
    mv_nxt     = mv_r;
    ch_nxt     = ch_r;
    old_nxt    = old_r;
    vld_nxt    = vld_r;
    res_st_nxt = res_st_r;
    res_nxt    = res_r;
    s_we       = 1'b0;
    s_waddr    = saddr(pos_r);
    s_wdata    = mv_r;
    s_raddr    = saddr(pos_r);
    p_we       = 1'b0;
    p_waddr    = idx(mv_r.id);
    p_wdata    = pos_r;
    p_raddr    = idx(in_tdata[ID_W-1:0]);
    cmp_a      = mv_r.key;
    cmp_b      = s_rdata.key;

    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          op_nxt     = op_t'(in_tuser);
          id_nxt     = in_tdata[ID_W-1:0];
          nkey_nxt   = in_tdata[ID_W +: KEY_W];
          npay_nxt   = in_tdata[ID_W+KEY_W +: PAY_W];
          res_st_nxt = ST_OK;
          res_nxt    = '0;
          state_nxt  = S_LOOK;
        end
      end
      S_LOOK: begin
        pos_nxt = look_p;
        s_raddr = saddr(look_p);
        case (op_r)
          OP_INSERT: begin
            if (full) begin
              res_st_nxt = ST_FULL;
              state_nxt  = S_FIN;
            end else if (id_bad) begin
              res_st_nxt = ST_NOT_FOUND;
              state_nxt  = S_FIN;
            end else if (look_p != '0) begin
              res_st_nxt = ST_PRESENT;
              state_nxt  = S_FIN;
            end else begin
              cnt_nxt   = cnt_r + PW'(1);
              pos_nxt   = cnt_r + PW'(1);
              mv_nxt    = '{pay: npay_r, id: id_r, key: nkey_r};
              state_nxt = S_UP;
            end
          end
          OP_DELMIN: begin
            s_raddr = saddr(PW'(1));
            if (cnt_r == '0) begin
              res_st_nxt = ST_EMPTY;
              state_nxt  = S_FIN;
            end else begin
              state_nxt = S_RDTOP;
            end
          end
          default: begin  // rekey, remove
            if (look_p == '0) begin
              res_st_nxt = ST_NOT_FOUND;
              state_nxt  = S_FIN;
            end else begin
              state_nxt = S_RDOLD;
            end
          end
        endcase
      end
      S_RDOLD: begin
        old_nxt = s_rdata.key;
        if (op_r == OP_REKEY) begin
          // sift up on a smaller or equal key, down on a larger one
          mv_nxt    = '{pay: s_rdata.pay, id: s_rdata.id, key: nkey_r};
          cmp_a     = s_rdata.key;
          cmp_b     = nkey_r;
          state_nxt = cmp_lt ? S_DOWN : S_UP;
        end else begin
          res_nxt = '{pay: s_rdata.pay, id: id_r, key: s_rdata.key};
          vld_nxt[idx(id_r)] = 1'b0;
          cnt_nxt = cnt_r - PW'(1);
          s_raddr = saddr(cnt_r);
          state_nxt = (pos_r == cnt_r) ? S_FIN : S_RDLAST;
        end
      end
      S_RDTOP: begin
        res_nxt = s_rdata;
        vld_nxt[idx(s_rdata.id)] = 1'b0;
        s_raddr = saddr(cnt_r);
        cnt_nxt = cnt_r - PW'(1);
        state_nxt = (cnt_r > PW'(1)) ? S_RDLAST : S_FIN;
      end
      S_RDLAST: begin
        mv_nxt = s_rdata;
        if (op_r == OP_DELMIN) begin
          pos_nxt   = PW'(1);
          state_nxt = S_DOWN;
        end else begin
          cmp_a     = old_r;
          cmp_b     = s_rdata.key;
          state_nxt = cmp_lt ? S_DOWN : S_UP;
        end
      end
      S_UP: begin
        s_raddr = saddr(pos_r >> 1);
        if (pos_r > PW'(1)) begin
          state_nxt = S_UPC;
        end else begin
          s_we = 1'b1;
          p_we = 1'b1;
          vld_nxt[idx(mv_r.id)] = 1'b1;
          state_nxt = S_FIN;
        end
      end
      S_UPC: begin
        cmp_a = mv_r.key;
        cmp_b = s_rdata.key;
        s_we  = 1'b1;
        p_we  = 1'b1;
        if (cmp_lt) begin
          s_wdata   = s_rdata;
          p_waddr   = idx(s_rdata.id);
          pos_nxt   = pos_r >> 1;
          state_nxt = S_UP;
        end else begin
          vld_nxt[idx(mv_r.id)] = 1'b1;
          state_nxt = S_FIN;
        end
      end
      S_DOWN: begin
        s_raddr = saddr(c2[PW-1:0]);
        if (c2 <= (PW+1)'(cnt_r)) begin
          c_nxt     = c2[PW-1:0];
          state_nxt = S_DNL;
        end else begin
          s_we = 1'b1;
          p_we = 1'b1;
          vld_nxt[idx(mv_r.id)] = 1'b1;
          state_nxt = S_FIN;
        end
      end
      S_DNL: begin
        ch_nxt  = s_rdata;
        s_raddr = c_r[SAW-1:0];   // slot c+1
        state_nxt = (c_r < cnt_r) ? S_DNR : S_DNC;
      end
      S_DNR: begin
        cmp_a = s_rdata.key;
        cmp_b = ch_r.key;
        if (cmp_lt) begin
          ch_nxt = s_rdata;
          c_nxt  = c_r + PW'(1);
        end
        state_nxt = S_DNC;
      end
      S_DNC: begin
        cmp_a = ch_r.key;
        cmp_b = mv_r.key;
        s_we  = 1'b1;
        p_we  = 1'b1;
        if (cmp_lt) begin
          s_wdata   = ch_r;
          p_waddr   = idx(ch_r.id);
          pos_nxt   = c_r;
          state_nxt = S_DOWN;
        end else begin
          vld_nxt[idx(mv_r.id)] = 1'b1;
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (!out_valid_r || out_tready) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      vld_r       <= '0;
      cap_r       <= CAP_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      vld_r   <= vld_nxt;
      if (cfg_wr_en) begin
        cap_r <= cfg_wr_data;
      end
      if (state_r == S_FIN && (!out_valid_r || out_tready)) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    op_r     <= op_nxt;
    id_r     <= id_nxt;
    nkey_r   <= nkey_nxt;
    npay_r   <= npay_nxt;
    pos_r    <= pos_nxt;
    c_r      <= c_nxt;
    mv_r     <= mv_nxt;
    ch_r     <= ch_nxt;
    old_r    <= old_nxt;
    res_st_r <= res_st_nxt;
    res_r    <= res_nxt;
    if (state_r == S_FIN && (!out_valid_r || out_tready)) begin
      out_st_r <= res_st_r;
      out_r    <= res_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_st_r;
  assign out_tdata  = {out_r.pay, out_r.key, out_r.id};

endmodule

// File: hdl/imhq_chk.sv
module imhq_chk (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_tvalid,
  input logic                       in_tready,
  input logic                       out_tvalid,
  input logic                       out_tready,
  input logic [71:0]                out_tdata,
  input logic [imhq_pkg::ST_W-1:0]  out_tuser
);
  import imhq_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped while stalled");

  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("ready right after an accepted item");

  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tuser <= ST_EMPTY)
    else $error("status code out of range");

  a_refused_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != ST_OK |-> out_tdata == '0)
    else $error("refused item carries data");

endmodule

bind indexed_min_heap_queue_top imhq_chk u_imhq_chk (
  .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
  .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
  .out_tuser(out_tuser)
);

// File: tb/indexed_min_heap_queue_checker.sv
module indexed_min_heap_queue_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [71:0] in_tdata,
  input  logic [1:0]  in_tuser,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [71:0] out_tdata,
  input  logic [2:0]  out_tuser,
  input  logic        cfg_wr_en,
  input  logic [8:0]  cfg_wr_data,
  output int          fail_count,
  output int          results_owed
);
  import imhq_pkg::*;

  typedef struct packed {
    logic [2:0]  status;
    logic [71:0] data;
  } answer_t;

  logic [31:0] hk [1:256];
  logic [7:0]  hid [1:256];
  logic [31:0] hpay [1:256];
  logic [8:0]  where [0:255];
  int          count;
  logic [8:0]  cap_reg;
  answer_t     answers [$];

  // signed compare on keys
  function automatic bit lt(logic [31:0] a, logic [31:0] b);
    return $signed(a) < $signed(b);
  endfunction

  task automatic put(int p, logic [31:0] k, logic [7:0] i, logic [31:0] d);
    hk[p] = k; hid[p] = i; hpay[p] = d; where[i] = p[8:0];
  endtask

  task automatic heap_up(int p);
    logic [31:0] k, d;
    logic [7:0] i;
    k = hk[p]; i = hid[p]; d = hpay[p];
    while (p > 1 && lt(k, hk[p/2])) begin
      put(p, hk[p/2], hid[p/2], hpay[p/2]);
      p = p / 2;
    end
    put(p, k, i, d);
  endtask

  task automatic heap_down(int p);
    logic [31:0] k, d;
    logic [7:0] i;
    int c;
    k = hk[p]; i = hid[p]; d = hpay[p];
    while (2 * p <= count) begin
      c = 2 * p;
      if (c < count && lt(hk[c+1], hk[c])) c++;
      if (!lt(hk[c], k)) break;
      put(p, hk[c], hid[c], hpay[c]);
      p = c;
    end
    put(p, k, i, d);
  endtask

  function automatic int find_id(logic [7:0] i);
    if (where[i] == 0 || where[i] > count) return 0;
    return where[i];
  endfunction

  task automatic heap_apply(logic [1:0] op, logic [71:0] d);
    logic [7:0]  i;
    logic [31:0] k, pay, old, mk;
    answer_t a;
    int cap, p, last;
    i = d[7:0]; k = d[39:8]; pay = d[71:40];
    a = '0; a.status = ST_OK;
    cap = (cap_reg > 256) ? 256 : cap_reg;
    case (op)
      OP_INSERT: begin
        if (count >= cap) a.status = ST_FULL;
        else if (find_id(i) != 0) a.status = ST_PRESENT;
        else begin
          count++;
          put(count, k, i, pay);
          heap_up(count);
        end
      end
      OP_REKEY: begin
        p = find_id(i);
        if (p == 0) a.status = ST_NOT_FOUND;
        else begin
          old = hk[p]; hk[p] = k;
          if (lt(k, old)) heap_up(p);
          else if (lt(old, k)) heap_down(p);
        end
      end
      OP_DELMIN: begin
        if (count == 0) a.status = ST_EMPTY;
        else begin
          a.data = {hpay[1], hk[1], hid[1]};
          where[hid[1]] = 0;
          if (count > 1) begin
            last = count; count--;
            put(1, hk[last], hid[last], hpay[last]);
            heap_down(1);
          end else count = 0;
        end
      end
      default: begin
        p = find_id(i);
        if (p == 0) a.status = ST_NOT_FOUND;
        else begin
          old = hk[p]; last = count;
          a.data = {hpay[p], old, i};
          where[i] = 0;
          count--;
          if (p != last) begin
            mk = hk[last];
            put(p, mk, hid[last], hpay[last]);
            if (lt(mk, old)) heap_up(p);
            else if (lt(old, mk)) heap_down(p);
          end
        end
      end
    endcase
    answers.push_back(a);
  endtask

  always @(posedge clk) begin
    answer_t exp_a;
    if (!rst_n) begin
      for (int n = 0; n < 256; n++) where[n] = 0;
      count = 0;
      cap_reg = CAP_RESET;
      answers.delete();
      fail_count = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (answers.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("unexpected result st=%0d data=%h", out_tuser, out_tdata);
        end else begin
          exp_a = answers.pop_front();
          if (exp_a.status !== out_tuser || exp_a.data !== out_tdata) begin
            fail_count++;
            if (fail_count <= 10)
              $display("mismatch: exp st=%0d data=%h got st=%0d data=%h",
                       exp_a.status, exp_a.data, out_tuser, out_tdata);
          end
        end
      end
      if (in_tvalid && in_tready) heap_apply(in_tuser, in_tdata);
      if (cfg_wr_en) cap_reg = cfg_wr_data;
    end
    results_owed = answers.size();
  end
endmodule

// File: tb/indexed_min_heap_queue_top_tb.sv
module indexed_min_heap_queue_top_tb;
  import imhq_pkg::*;

  localparam int WATCHDOG = 20000;

  logic        clk = 0;
  logic        rst_n = 0;
  logic        in_tvalid = 0;
  logic        in_tready;
  logic [71:0] in_tdata = '0;
  logic [1:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 0;
  logic [71:0] out_tdata;
  logic [2:0]  out_tuser;
  logic        cfg_wr_en = 0;
  logic [8:0]  cfg_wr_data = '0;
  int          fail_count;
  int          results_owed;
  int          quiet_cycles = 0;
  bit          calm = 0;      // no idling while set

  always #5 clk = ~clk;

  indexed_min_heap_queue_top uut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
  );

  indexed_min_heap_queue_checker chk (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .fail_count(fail_count), .results_owed(results_owed)
  );

  // receiver stalls about 11% of cycles
  always @(negedge clk)
    out_tready <= calm ? 1'b1 : ($urandom_range(99) >= 11);

  // watchdog: cycles with no item moving on either side
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || !rst_n) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // present one item; random gap first, held until accepted
  // the block is busy in S_LOOK and S_FIN after an accept, so the leading
  // negedge costs no throughput and keeps the valid drop and raise apart
  task automatic send_op(op_t op, logic [7:0] id, logic [31:0] key, logic [31:0] pay);
    @(negedge clk);
    while (!calm && $urandom_range(99) < 11) @(negedge clk);
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {pay, key, id};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
    in_tvalid <= 1'b0;
  endtask

  // wait out every result, plus tail latency, then idle-only write
  task automatic drain();
    while (results_owed != 0) @(negedge clk);
    repeat (50) @(negedge clk);
  endtask

  task automatic set_capacity(logic [8:0] v);
    drain();
    cfg_wr_en <= 1'b1; cfg_wr_data <= v;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  function automatic logic [31:0] pick_key();
    case ($urandom_range(7))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return $urandom_range(7);          // many ties
      3: return 32'h0 - $urandom_range(7);
      default: return $urandom;
    endcase
  endfunction

  // random phase: ids drawn from 0..id_span; a small span makes hits dominate
  task automatic random_phase(int n, int id_span, int mix);
    op_t op;
    for (int j = 0; j < n; j++) begin
      case ($urandom_range(9))
        0, 1, 2, 3: op = (mix > 0) ? OP_INSERT : OP_DELMIN;
        4, 5: op = OP_REKEY;
        6, 7: op = OP_DELMIN;
        default: op = OP_REMOVE;
      endcase
      if (mix > 1 && $urandom_range(1)) op = OP_INSERT;
      send_op(op, 8'((id_span >= 255) ? $urandom : $urandom_range(id_span)),
              pick_key(), $urandom);
    end
  endtask

  initial begin
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: empty, extremes, ties, dup, not found, last-slot remove
    send_op(OP_DELMIN, 8'd0, 32'h0, 32'h0);
    send_op(OP_REMOVE, 8'd5, 32'h0, 32'h0);
    send_op(OP_REKEY, 8'd5, 32'h0, 32'h0);
    send_op(OP_INSERT, 8'd0, 32'h7fff_ffff, 32'hffff_ffff);
    send_op(OP_INSERT, 8'd255, 32'h8000_0000, 32'h0);
    send_op(OP_INSERT, 8'd255, 32'h1, 32'h1);
    send_op(OP_INSERT, 8'd10, 32'h5, 32'haaaa_5555);
    send_op(OP_INSERT, 8'd11, 32'h5, 32'h5555_aaaa);
    send_op(OP_INSERT, 8'd12, 32'h5, 32'h1234_5678);
    send_op(OP_REKEY, 8'd10, 32'h5, 32'h0);
    send_op(OP_REKEY, 8'd0, 32'hffff_fff0, 32'h0);
    send_op(OP_REKEY, 8'd255, 32'h7fff_ffff, 32'h0);
    send_op(OP_REMOVE, 8'd11, 32'h0, 32'h0);
    send_op(OP_REMOVE, 8'd12, 32'h0, 32'h0);
    send_op(OP_DELMIN, 8'd0, 32'h0, 32'h0);
    send_op(OP_REMOVE, 8'd255, 32'h0, 32'h0);
    send_op(OP_DELMIN, 8'd0, 32'h0, 32'h0);
    send_op(OP_DELMIN, 8'd0, 32'h0, 32'h0);

    // capacity zero, then one
    set_capacity(9'd0);
    send_op(OP_INSERT, 8'd3, 32'h0, 32'h0);
    set_capacity(9'd1);
    send_op(OP_INSERT, 8'd3, 32'h9, 32'h9);
    send_op(OP_INSERT, 8'd4, 32'h1, 32'h1);
    send_op(OP_DELMIN, 8'd0, 32'h0, 32'h0);

    // small capacity, fill and churn
    set_capacity(9'd7);
    random_phase(150, 15, 1);
    // saturating capacity, fill deep, no idling stretch
    set_capacity(9'd511);
    calm = 1;
    random_phase(300, 255, 2);
    calm = 0;
    // sender holds off until every result is back
    drain();
    // lower capacity beneath the current count
    set_capacity(9'd3);
    random_phase(100, 63, 1);
    set_capacity(9'd256);
    random_phase(350, 255, 1);
    set_capacity(9'd40);
    random_phase(300, 47, 1);

    drain();
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule

// File: files.f
hdl/imhq_pkg.sv
hdl/imhq_ram.sv
hdl/imhq_cmp.sv
hdl/indexed_min_heap_queue_top.sv
hdl/imhq_chk.sv
tb/indexed_min_heap_queue_checker.sv
tb/indexed_min_heap_queue_top_tb.sv
